>>> design/cle_pkg.sv
`timescale 1ns / 1ps

package cle_pkg;

   // Fixed field widths of the console channel and the command table.
   localparam int CHAR_W       = 8;
   localparam int ENTRY_W      = 64;
   localparam int ID_W         = 8;
   localparam int LENGTH_W     = 7;
   localparam int CSR_INDEX_W  = 3;

   // Special character codes.
   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_ETX   = 8'h03;
   localparam logic [CHAR_W-1:0] CHAR_ESC   = 8'h1B;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_MATCH   = 2'd2,
      ST_UNKNOWN = 2'd3
   } line_status_type;

   typedef enum logic [2:0] {
      CC_IGNORE,
      CC_BACKSPACE,
      CC_CLEAR,
      CC_LINE_END,
      CC_PRINTABLE
   } char_class_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_CMP,
      S_DONE
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            accept;
      logic            scan_run;
      logic            cmp_next;
      logic            result_set;
      line_status_type result_code;
      logic            load_out;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic line_end;
      logic scan_end;
      logic token_found;
      logic entry_end;
      logic entry_hit;
      logic last_entry;
      logic out_free;
   } dp_sts_type;

   function automatic char_class_type classify_char(input logic [CHAR_W-1:0] c);
      char_class_type cls;
      case (c)
         CHAR_BS:           cls = CC_BACKSPACE;
         CHAR_ESC, CHAR_ETX: cls = CC_CLEAR;
         CHAR_CR, CHAR_LF:  cls = CC_LINE_END;
         default:           cls = (c >= CHAR_SPACE) ? CC_PRINTABLE : CC_IGNORE;
      endcase
      return cls;
   endfunction

endpackage

>>> design/cle_ctrl.sv
`timescale 1ns / 1ps

module cle_ctrl
   import cle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = sts.line_end ? S_SCAN : S_DONE;
            end
         end
         S_SCAN: begin
            if (sts.scan_end) begin
               state_in = sts.token_found ? S_CMP : S_DONE;
            end
         end
         S_CMP: begin
            if (sts.entry_end || sts.entry_hit || sts.last_entry) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd             = '0;
      cmd.result_code = ST_NONE;
      req_stall       = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_end && !sts.token_found) begin
               cmd.result_set  = 1'b1;
               cmd.result_code = ST_EMPTY;
            end
         end
         S_CMP: begin
            if (sts.entry_end) begin
               cmd.result_set  = 1'b1;
               cmd.result_code = ST_UNKNOWN;
            end else if (sts.entry_hit) begin
               cmd.result_set  = 1'b1;
               cmd.result_code = ST_MATCH;
            end else if (sts.last_entry) begin
               cmd.result_set  = 1'b1;
               cmd.result_code = ST_UNKNOWN;
            end else begin
               cmd.cmp_next = 1'b1;
            end
         end
         S_DONE: begin
            cmd.load_out = sts.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

>>> design/cle_datapath.sv
`timescale 1ns / 1ps

module cle_datapath
   import cle_pkg::*;
#(
   parameter int LINE_CAPACITY = 64,
   parameter int TABLE_ENTRIES = 8,
   parameter int KEYWORD_CHARS = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CHAR_W-1:0]      req_char_code,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_line_status,
   output logic [ID_W-1:0]        rsp_matched_id,
   output logic [LENGTH_W-1:0]    rsp_current_length,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ENTRY_W-1:0]     csr_data,
   input  dp_cmd_type             cmd,
   output dp_sts_type             sts
);

   localparam int AW   = $clog2(LINE_CAPACITY);
   localparam int LW   = $clog2(LINE_CAPACITY + 1);
   localparam int EW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int TLW  = $clog2(KEYWORD_CHARS + 2);

   // Command table.
   logic [ENTRY_W-1:0] cfg_ff [TABLE_ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_valid && ({1'b0, csr_index} < (CSR_INDEX_W + 1)'(TABLE_ENTRIES))) begin
         cfg_ff[csr_index[EW-1:0]] <= csr_data;
      end
   end

   // Edit line storage and scan state.
   logic [CHAR_W-1:0] line_mem [LINE_CAPACITY];
   logic [CHAR_W-1:0] rd_data_ff;
   logic              rd_vld_ff;
   logic [LW-1:0]     len_ff;
   logic [LW-1:0]     len_in;
   logic [LW-1:0]     scan_idx_ff;
   logic              in_tok_ff;
   logic              tok_done_ff;
   logic [TLW-1:0]    tlen_ff;
   logic [KEYWORD_CHARS-1:0][CHAR_W-1:0] tok_ff;
   logic [EW-1:0]     entry_ff;
   line_status_type   status_ff;
   logic [ID_W-1:0]   id_ff;
   logic              rsp_valid_ff;
   logic [1:0]        out_status_ff;
   logic [ID_W-1:0]   out_id_ff;
   logic [LENGTH_W-1:0] out_len_ff;

   char_class_type     cls;
   logic               len_room;
   logic               issue;
   logic               take_char;
   logic [ENTRY_W-1:0] entry;
   logic               kw_nonzero;
   logic [TLW-1:0]     klen;
   logic               klen_found;
   logic               chars_equal;

   assign cls       = classify_char(req_char_code);
   assign len_room  = len_ff < LW'(LINE_CAPACITY);
   assign issue     = cmd.scan_run && (scan_idx_ff < len_ff);
   assign take_char = cmd.scan_run && rd_vld_ff && !tok_done_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept && (cls == CC_PRINTABLE) && len_room) begin
         line_mem[len_ff[AW-1:0]] <= req_char_code;
      end
      rd_data_ff <= line_mem[scan_idx_ff[AW-1:0]];
   end

   always_comb begin
      len_in = len_ff;
      if (cmd.accept) begin
         case (cls)
            CC_BACKSPACE: if (len_ff != '0) len_in = len_ff - LW'(1);
            CC_CLEAR:     len_in = '0;
            CC_PRINTABLE: if (len_room) len_in = len_ff + LW'(1);
            default:      len_in = len_ff;
         endcase
      end else if (cmd.result_set) begin
         len_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   // Token extraction: one stored character per cycle, read data taken from a registered memory read.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         scan_idx_ff <= '0;
         in_tok_ff   <= 1'b0;
         tok_done_ff <= 1'b0;
         tlen_ff     <= '0;
      end else if (cmd.accept) begin
         rd_vld_ff   <= 1'b0;
         scan_idx_ff <= '0;
         in_tok_ff   <= 1'b0;
         tok_done_ff <= 1'b0;
         tlen_ff     <= '0;
      end else begin
         rd_vld_ff <= issue;
         if (issue) begin
            scan_idx_ff <= scan_idx_ff + LW'(1);
         end
         if (take_char) begin
            if (rd_data_ff == CHAR_SPACE) begin
               if (in_tok_ff) begin
                  tok_done_ff <= 1'b1;
               end
            end else begin
               in_tok_ff <= 1'b1;
               if (tlen_ff != TLW'(KEYWORD_CHARS + 1)) begin
                  tlen_ff <= tlen_ff + TLW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < KEYWORD_CHARS; k++) begin
         if (take_char && (rd_data_ff != CHAR_SPACE) && (tlen_ff == TLW'(k))) begin
            tok_ff[k] <= rd_data_ff;
         end
      end
   end

   // Keyword compare against one table entry per cycle.
   assign entry = cfg_ff[entry_ff];

   always_comb begin
      kw_nonzero  = 1'b0;
      klen        = TLW'(KEYWORD_CHARS);
      klen_found  = 1'b0;
      chars_equal = 1'b1;
      for (int k = 0; k < KEYWORD_CHARS; k++) begin
         if (entry[8 + 8 * k +: 8] != '0) begin
            kw_nonzero = 1'b1;
         end
         if (!klen_found && (entry[8 + 8 * k +: 8] == '0)) begin
            klen_found = 1'b1;
            klen       = TLW'(k);
         end
         if ((TLW'(k) < tlen_ff) && (tok_ff[k] != entry[8 + 8 * k +: 8])) begin
            chars_equal = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (cmd.accept) begin
         entry_ff <= '0;
      end else if (cmd.cmp_next) begin
         entry_ff <= entry_ff + EW'(1);
      end
   end

   // Per-item result.
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_NONE;
         id_ff     <= '0;
      end else if (cmd.accept) begin
         status_ff <= ST_NONE;
         id_ff     <= '0;
      end else if (cmd.result_set) begin
         status_ff <= cmd.result_code;
         id_ff     <= (cmd.result_code == ST_MATCH) ? entry[ID_W-1:0] : '0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status_ff <= status_ff;
         out_id_ff     <= id_ff;
         out_len_ff    <= LENGTH_W'(len_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_status    = out_status_ff;
   assign rsp_matched_id     = out_id_ff;
   assign rsp_current_length = out_len_ff;

   assign sts.line_end    = (cls == CC_LINE_END);
   assign sts.scan_end    = tok_done_ff || (!(scan_idx_ff < len_ff) && !rd_vld_ff);
   assign sts.token_found = in_tok_ff;
   assign sts.entry_end   = !kw_nonzero;
   assign sts.entry_hit   = (klen != '0) && (klen == tlen_ff) && chars_equal;
   assign sts.last_entry  = (entry_ff == EW'(TABLE_ENTRIES - 1));
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

endmodule

>>> design/command_line_editor_matcher_unit.sv
// Any character other than a line end goes from acceptance straight to the result hand-off;
// a line end first walks the stored line (one stored character per cycle) and, if a token was
// found, compares table entries in order up to a hit, a table end or the last entry. Results
// load into the output register once it is free; the next item is taken only after that.
// Reset (synchronous, active high) empties the line, clears the command table to zero and
// drops any pending result; the line memory itself is not cleared.
`timescale 1ns / 1ps

module command_line_editor_matcher_unit
   import cle_pkg::*;
#(
   parameter int LINE_CAPACITY = 64,
   parameter int TABLE_ENTRIES = 8,
   parameter int KEYWORD_CHARS = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CHAR_W-1:0]      req_char_code,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_line_status,
   output logic [ID_W-1:0]        rsp_matched_id,
   output logic [LENGTH_W-1:0]    rsp_current_length,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ENTRY_W-1:0]     csr_data
);

   // The controller sequences items through accept, line walk and table compare (line ends
   // only) and result hand-off; the datapath holds the line memory, the command table, the
   // token buffer and the output register.
   dp_cmd_type cmd;
   dp_sts_type sts;

   // Table writes must come only while idle; the block does not enforce it. No back-pressure.
   assign csr_ready = 1'b1;

   cle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cle_datapath #(
      .LINE_CAPACITY (LINE_CAPACITY),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_char_code      (req_char_code),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_line_status    (rsp_line_status),
      .rsp_matched_id     (rsp_matched_id),
      .rsp_current_length (rsp_current_length),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .cmd                (cmd),
      .sts                (sts)
   );

`ifndef SYNTH
   // Once a transaction is taken the block is busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted twice in back-to-back cycles");

   // Only a matched line carries a command id.
   a_id_only_on_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_line_status != ST_MATCH)) |-> (rsp_matched_id == '0))
      else $error("nonzero id without a keyword match");

   // Every line event leaves the edit line empty.
   a_line_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_line_status != ST_NONE)) |-> (rsp_current_length == '0))
      else $error("line not cleared after a line event");
`endif

endmodule

>>> bench/command_line_editor_matcher_monitor.sv
`timescale 1ns / 1ps

module command_line_editor_matcher_monitor
   import cle_pkg::*;
#(
   parameter int LINE_CAPACITY = 64,
   parameter int TABLE_ENTRIES = 8,
   parameter int KEYWORD_CHARS = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [CHAR_W-1:0]      req_char_code,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [1:0]             rsp_line_status,
   input  logic [ID_W-1:0]        rsp_matched_id,
   input  logic [LENGTH_W-1:0]    rsp_current_length,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ENTRY_W-1:0]     csr_data,
   output int                     mismatch_count,
   output int                     pending_count
);

   localparam int REGISTER_COUNT = 8;

   typedef struct packed {
      line_status_type       status;
      logic [ID_W-1:0]       id;
      logic [LENGTH_W-1:0]   length;
   } line_outcome_type;

   logic [CHAR_W-1:0]  edit_line [LINE_CAPACITY];
   int unsigned        edit_length;
   logic [ENTRY_W-1:0] command_table [REGISTER_COUNT];
   line_outcome_type   awaited_outcomes [$];

   // Number of keyword characters before the first zero character.
   function automatic int unsigned keyword_length(logic [ENTRY_W-1:0] entry);
      int unsigned n;
      n = 0;
      while (n < KEYWORD_CHARS && entry[8 + 8 * n +: 8] != 8'h00) n++;
      return n;
   endfunction

   // Looks up the token edit_line[start +: span] in the table, first hit wins.
   function automatic line_outcome_type look_up_token(int unsigned start, int unsigned span);
      line_outcome_type o;
      logic [ENTRY_W-1:0] entry;
      int unsigned      e;
      int unsigned      k;
      logic             table_open;
      logic             hit;
      o.status = ST_UNKNOWN;
      o.id = '0;
      o.length = '0;
      table_open = 1'b1;
      for (e = 0; e < TABLE_ENTRIES && e < REGISTER_COUNT && table_open; e++) begin
         entry = command_table[e];
         table_open = 1'b0;
         for (k = 0; k < KEYWORD_CHARS; k++) begin
            if (entry[8 + 8 * k +: 8] != 8'h00) table_open = 1'b1;
         end
         if (table_open && keyword_length(entry) != 0 && keyword_length(entry) == span) begin
            hit = 1'b1;
            for (k = 0; k < span; k++) begin
               if (edit_line[start + k] != entry[8 + 8 * k +: 8]) hit = 1'b0;
            end
            if (hit) begin
               o.status = ST_MATCH;
               o.id = entry[ID_W-1:0];
               table_open = 1'b0;
            end
         end
      end
      return o;
   endfunction

   // Applies one received character to the edit line and returns the outcome.
   function automatic line_outcome_type step_editor(logic [CHAR_W-1:0] code);
      line_outcome_type o;
      int unsigned   pos;
      int unsigned   start;
      o.status = ST_NONE;
      o.id = '0;
      if (code == CHAR_BS) begin
         if (edit_length > 0) edit_length--;
      end else if (code == CHAR_ESC || code == CHAR_ETX) begin
         edit_length = 0;
      end else if (code == CHAR_CR || code == CHAR_LF) begin
         pos = 0;
         while (pos < edit_length && edit_line[pos] == CHAR_SPACE) pos++;
         if (pos >= edit_length) begin
            o.status = ST_EMPTY;
         end else begin
            start = pos;
            while (pos < edit_length && edit_line[pos] != CHAR_SPACE) pos++;
            o = look_up_token(start, pos - start);
         end
         edit_length = 0;
      end else if (code >= CHAR_SPACE) begin
         if (edit_length < LINE_CAPACITY) begin
            edit_line[edit_length] = code;
            edit_length++;
         end
      end
      o.length = LENGTH_W'(edit_length);
      return o;
   endfunction

   always @(posedge clock) begin : watch
      line_outcome_type want;
      if (reset) begin
         edit_length = 0;
         for (int r = 0; r < REGISTER_COUNT; r++) command_table[r] = '0;
         awaited_outcomes.delete();
         mismatch_count = 0;
      end else begin
         // A result can never belong to a character accepted at the same edge,
         // so the comparison runs before the new prediction is queued.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_outcomes.size() == 0) begin
               $error("result transaction arrived with no line outcome pending");
               mismatch_count++;
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_line_status !== want.status) begin
                  $error("line_status: expected %0d, actual %0d", want.status, rsp_line_status);
                  mismatch_count++;
               end
               if (rsp_matched_id !== want.id) begin
                  $error("matched_id: expected %0d, actual %0d", want.id, rsp_matched_id);
                  mismatch_count++;
               end
               if (rsp_current_length !== want.length) begin
                  $error("current_length: expected %0d, actual %0d",
                         want.length, rsp_current_length);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) command_table[csr_index] = csr_data;
         if (req_valid && !req_stall) begin
            awaited_outcomes.insert(awaited_outcomes.size(), step_editor(req_char_code));
         end
      end
      pending_count <= awaited_outcomes.size();
   end

endmodule

>>> bench/command_line_editor_matcher_unit_test.sv
`timescale 1ns / 1ps

// Top level of the line editor bench. It only makes stimulus and gives the verdict;
// prediction and comparison live in the monitor that sits beside the block.
module command_line_editor_matcher_unit_test;
   import cle_pkg::*;

   // Worst line end is a walk over a full line plus a compare of every table entry,
   // with some margin for the output register and the handshake.
   localparam int LINE_WALK_CYCLES = 64 + 8 + 12;
   localparam int ITEMS_PER_SHAPE  = 175;

   // Shapes of the command table used for the random phases. Together they reach
   // the extremes: nothing configured, every bit set, and fully random contents.
   typedef enum int {
      TBL_EMPTY,
      TBL_ALL_ONES,
      TBL_SHORT_ALPHA,
      TBL_GAPS,
      TBL_MIXED_LEN,
      TBL_RANDOM
   } table_shape_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [CHAR_W-1:0]      req_char_code;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [1:0]             rsp_line_status;
   logic [ID_W-1:0]        rsp_matched_id;
   logic [LENGTH_W-1:0]    rsp_current_length;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [ENTRY_W-1:0]     csr_data;

   int mismatch_count;
   int pending_count;

   // Contents that the stimulus last wrote to the table, so that command lines can
   // be built around keywords that actually exist.
   logic [ENTRY_W-1:0] keyword_plan [8];

   // Counts characters the block acts on; ignored control bytes are left out.
   int unsigned items_sent;

   // While calm is set neither side inserts idle cycles, giving back-to-back stretches.
   bit calm;

   command_line_editor_matcher_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_line_status    (rsp_line_status),
      .rsp_matched_id     (rsp_matched_id),
      .rsp_current_length (rsp_current_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   command_line_editor_matcher_monitor i_monitor (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_line_status    (rsp_line_status),
      .rsp_matched_id     (rsp_matched_id),
      .rsp_current_length (rsp_current_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Packs a keyword string and an id into one table entry.
   function automatic logic [ENTRY_W-1:0] make_entry(string word, logic [ID_W-1:0] id);
      logic [ENTRY_W-1:0] v;
      v = '0;
      v[ID_W-1:0] = id;
      for (int k = 0; k < word.len() && k < 7; k++) v[8 + 8 * k +: 8] = word[k];
      return v;
   endfunction

   // Random keyword of the given length. Narrow keywords use a four-letter alphabet
   // so that random lines hit them often; wide ones use any byte from 33 to 255.
   function automatic logic [ENTRY_W-1:0] make_keyword(int unsigned len, bit wide);
      logic [ENTRY_W-1:0] v;
      v = '0;
      v[ID_W-1:0] = ID_W'($urandom_range(0, 255));
      for (int k = 0; k < len && k < 7; k++) begin
         v[8 + 8 * k +: 8] = wide ? 8'($urandom_range(33, 255))
                                  : 8'(8'h61 + $urandom_range(0, 3));
      end
      return v;
   endfunction

   // Printable byte, mostly plain ASCII but now and then from the upper half.
   function automatic logic [CHAR_W-1:0] any_printable();
      if ($urandom_range(0, 7) == 0) return CHAR_W'($urandom_range(128, 255));
      return CHAR_W'($urandom_range(33, 126));
   endfunction

   // Presents one character after a random gap and holds it until it is taken.
   // The valid is only lowered when a gap follows, so it never drops and rises
   // again in one time step.
   task automatic send_char(input logic [CHAR_W-1:0] code);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= code;
      do @(posedge clock); while (req_stall);
      if (code >= CHAR_SPACE || code == CHAR_BS || code == CHAR_ESC || code == CHAR_ETX ||
          code == CHAR_CR || code == CHAR_LF) begin
         items_sent++;
      end
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_char(text[i]);
   endtask

   // Writes all eight table entries back to back. The valid stays high across the
   // writes and is lowered once after the last transaction.
   task automatic program_table();
      for (int r = 0; r < 8; r++) begin
         csr_valid <= 1'b1;
         csr_index <= r[CSR_INDEX_W-1:0];
         csr_data <= keyword_plan[r];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Waits until every predicted result has come back, then lets a full line walk
   // pass so that the block is surely idle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LINE_WALK_CYCLES) @(posedge clock);
   endtask

   task automatic plan_table(input table_shape_type shape);
      for (int r = 0; r < 8; r++) begin
         case (shape)
            TBL_EMPTY: begin
               keyword_plan[r] = '0;
            end
            TBL_ALL_ONES: begin
               keyword_plan[r] = '1;
            end
            TBL_SHORT_ALPHA: begin
               keyword_plan[r] = make_keyword($urandom_range(1, 4), 1'b0);
            end
            TBL_GAPS: begin
               // Mix of normal keywords, table ends, and empty keywords whose later
               // characters are set, which neither end the table nor match.
               case ($urandom_range(0, 9))
                  0, 1:    keyword_plan[r] = {56'h0, 8'($urandom_range(0, 255))};
                  2, 3: begin
                     keyword_plan[r] = make_keyword($urandom_range(2, 7), 1'b0);
                     keyword_plan[r][15:8] = 8'h00;
                  end
                  default: keyword_plan[r] = make_keyword($urandom_range(1, 7), 1'b0);
               endcase
            end
            TBL_MIXED_LEN: begin
               keyword_plan[r] = make_keyword(r[0] ? 7 : 1, 1'($urandom_range(0, 1)));
            end
            default: begin
               keyword_plan[r] = {$urandom, $urandom};
            end
         endcase
      end
   endtask

   // Sends one line. Most lines are well formed: optional leading spaces, a token
   // built from a configured keyword (exact or slightly changed), optional arguments
   // and a line end. The rest are cancelled lines, near-full or overflowing lines,
   // lines of only spaces and raw noise.
   task automatic send_command_line();
      logic [ENTRY_W-1:0] entry;
      logic [CHAR_W-1:0]  token [$];
      int unsigned        kind;
      int unsigned        pick;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         entry = keyword_plan[$urandom_range(0, 7)];
         for (int k = 0; k < 7 && entry[8 + 8 * k +: 8] != 8'h00; k++) begin
            token.insert(token.size(), entry[8 + 8 * k +: 8]);
         end
         if (token.size() == 0) begin
            repeat ($urandom_range(1, 3)) begin
               token.insert(token.size(), CHAR_W'(8'h61 + $urandom_range(0, 3)));
            end
         end
         case ($urandom_range(0, 9))
            6: if (token.size() > 1) void'(token.pop_back());
            7: token.insert(token.size(), CHAR_W'(8'h61 + $urandom_range(0, 3)));
            8: begin
               pick = $urandom_range(0, token.size() - 1);
               token[pick] = token[pick] ^ 8'h01;
            end
            9: while (token.size() < 8) token.insert(token.size(), 8'h61);
            default: ;
         endcase
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_char(CHAR_SPACE);
         foreach (token[i]) send_char(token[i]);
         // A stray character rubbed out again must leave the token unchanged.
         if ($urandom_range(0, 6) == 0) begin
            send_char(any_printable());
            send_char(CHAR_BS);
         end
         if ($urandom_range(0, 1) == 1) begin
            send_char(CHAR_SPACE);
            repeat ($urandom_range(1, 6)) send_char(any_printable());
         end
         send_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      end else if (kind < 80) begin
         repeat ($urandom_range(1, 5)) send_char(any_printable());
         case ($urandom_range(0, 2))
            0: send_char(CHAR_ESC);
            1: send_char(CHAR_ETX);
            default: repeat ($urandom_range(1, 7)) send_char(CHAR_BS);
         endcase
         if ($urandom_range(0, 1) == 1) send_char(CHAR_CR);
      end else if (kind < 85) begin
         // Runs near, up to or past the line capacity, so that any excess bytes are dropped.
         repeat ($urandom_range(60, 72)) send_char(any_printable());
         if ($urandom_range(0, 1) == 1) send_char(CHAR_BS);
         send_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      end else if (kind < 90) begin
         repeat ($urandom_range(0, 4)) send_char(CHAR_SPACE);
         send_char(CHAR_LF);
      end else begin
         repeat ($urandom_range(1, 6)) send_char(CHAR_W'($urandom_range(0, 255)));
      end
   endtask

   // Response side: before each result it stalls for a random number of cycles,
   // then takes the transaction as soon as it is offered.
   initial begin : result_sink
      int unsigned hold;
      forever begin
         hold = calm ? 0 : $urandom_range(0, 4);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      table_shape_type shape;
      int unsigned  goal;
      calm = 1'b0;
      items_sent = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_char_code <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table: a duplicate keyword where the first entry must win, an empty
      // keyword with a later character set, a full seven-character keyword, upper-half
      // bytes, an entry that ends the table, an entry behind it that must never match,
      // and an entry with every bit set.
      keyword_plan[0] = make_entry("go", 8'hFF);
      keyword_plan[1] = 64'h0000_0000_0078_0055;
      keyword_plan[2] = make_entry("abcdefg", 8'h00);
      keyword_plan[3] = 64'h0000_0000_0080_FF80;
      keyword_plan[4] = make_entry("go", 8'h01);
      keyword_plan[5] = '0;
      keyword_plan[6] = make_entry("zz", 8'h03);
      keyword_plan[7] = '1;
      program_table();

      // Empty line, backspace on an empty line, and two ignored control bytes.
      send_char(CHAR_LF);
      send_char(CHAR_BS);
      send_char(8'h00);
      send_char(8'h1F);
      // Exact match, then a match behind leading spaces with an argument.
      send_text("go");
      send_char(CHAR_CR);
      send_text(" go x");
      send_char(CHAR_LF);
      // A keyword behind the table end is unknown.
      send_text("zz");
      send_char(CHAR_CR);
      // Upper-half bytes in the keyword.
      send_char(8'hFF);
      send_char(8'h80);
      send_char(CHAR_CR);
      // The empty keyword never matches even though its later character is set.
      send_text("x");
      send_char(CHAR_CR);
      // Clear by escape and by control-C, then a line of only spaces.
      send_text("ab");
      send_char(CHAR_ESC);
      send_char(CHAR_CR);
      send_char(8'h7F);
      send_char(CHAR_ETX);
      send_text("  ");
      send_char(CHAR_CR);
      drain();

      // Random phases, one per table shape. The table is only rewritten once the
      // block has returned every result and gone idle.
      shape = TBL_EMPTY;
      goal = items_sent;
      for (int p = 0; p < 6; p++) begin
         plan_table(shape);
         program_table();
         goal += ITEMS_PER_SHAPE;
         while (items_sent < goal) begin
            if ($urandom_range(0, 5) == 0) calm = ($urandom_range(0, 3) == 0);
            send_command_line();
         end
         drain();
         shape = shape.next();
      end

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Safety net far beyond the slowest legal run.
   initial begin : watchdog
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
